### src/assert_macros.svh
// Assertion macros for the RTL files; the top level includes them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// The property must hold at every clock edge outside reset.
`define STC_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("stc assertion failed");
// The condition must never be true outside reset.
`define STC_NEVER(lbl, clk, rst_n, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("stc forbidden condition seen");
`else
`define STC_ASSERT(lbl, clk, rst_n, prop)
`define STC_NEVER(lbl, clk, rst_n, cond)
`endif
`endif

### src/stc_pkg.sv
// Shared types and constants of the slow-time clutter filter.
package stc_pkg;
    localparam int TAPS = 4;
    localparam int SLOT_W = $clog2(TAPS);
    localparam int GATE_W = 12;
    localparam int GATES = 4096;
    localparam int HIST_AW = 1 + GATE_W;
    localparam int HIST_DEPTH = 2 * GATES;
    localparam int SMP_W = 16;
    localparam int COEF_W = 16;
    localparam int PROD_W = SMP_W + COEF_W;
    localparam int ACC_W = PROD_W + $clog2(2 * TAPS);
    localparam int FRAC_SHIFT = 12;
    localparam int LEN_W = 3;
    localparam int GCNT_W = 13;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 64;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ENABLE = 3'd0,
        CFG_B_LEN  = 3'd1,
        CFG_A_LEN  = 3'd2,
        CFG_B_COEF = 3'd3,
        CFG_A_COEF = 3'd4,
        CFG_GCOUNT = 3'd5
    } t_cfg_idx;

    typedef logic signed [SMP_W-1:0] t_smp;
    typedef logic signed [COEF_W-1:0] t_coef;
    typedef logic signed [ACC_W-1:0] t_acc;

    typedef struct packed {
        t_smp q;
        t_smp i;
    } t_cplx;

    typedef struct packed {
        t_cplx               x;
        logic                pol;
        logic [GATE_W-1:0]   gate;
        logic                last;
        logic [SLOT_W-1:0]   slot;
        logic                filt;
        logic                pass;
    } t_meta;
endpackage

### src/slow_time_iir_clutter_filter.sv
// Top level of the pulse-to-pulse IIR clutter filter with its history RAMs.
// Pipeline: each input transfer passes stages s1, s2, s3 and the output register.
// Throughput: one transfer per cycle; input waits while the receiver holds the
// output register, and while an enabled sample of the same polarization and
// gate is still in the three compute stages, whose history is not written yet.
// Reset: synchronous, active low; after release a clearing pass writes zeros to
// all 8192 words of each history RAM, during which no input transfer is taken.
`include "assert_macros.svh"
module slow_time_iir_clutter_filter (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_ready,
    input  logic signed [stc_pkg::SMP_W-1:0]    i_sample_i,
    input  logic signed [stc_pkg::SMP_W-1:0]    i_sample_q,
    input  logic                                i_polarization,
    input  logic [stc_pkg::GATE_W-1:0]          i_gate,
    input  logic                                i_pulse_end,
    output logic                                o_valid,
    input  logic                                i_ready,
    output logic signed [stc_pkg::SMP_W-1:0]    o_filtered_i,
    output logic signed [stc_pkg::SMP_W-1:0]    o_filtered_q,
    output logic                                o_out_polarization,
    output logic [stc_pkg::GATE_W-1:0]          o_out_gate,
    output logic                                o_out_pulse_end,
    input  logic                                i_cfg_wr_en,
    input  logic [stc_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [stc_pkg::CFG_DATA_W-1:0]      i_cfg_data
);
    localparam int TAPS = stc_pkg::TAPS;
    localparam int HW = 2 * $bits(stc_pkg::t_cplx);
    localparam int QW = stc_pkg::ACC_W + 1 - stc_pkg::FRAC_SHIFT;
    localparam int SLOT_W_C = stc_pkg::SLOT_W;

    // Configuration registers.
    logic                               r_enable;
    logic [stc_pkg::LEN_W-1:0]          r_b_len, r_a_len;
    logic [TAPS*stc_pkg::COEF_W-1:0]    r_b_coef;
    logic [(TAPS-1)*stc_pkg::COEF_W-1:0] r_a_coef;
    logic [stc_pkg::GCNT_W-1:0]         r_gcount;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enable <= 1'b0;
            r_b_len  <= stc_pkg::LEN_W'(1);
            r_a_len  <= stc_pkg::LEN_W'(1);
            r_b_coef <= $bits(r_b_coef)'(4096);
            r_a_coef <= '0;
            r_gcount <= stc_pkg::GCNT_W'(4096);
        end else if (i_cfg_wr_en) begin
            unique case (stc_pkg::t_cfg_idx'(i_cfg_index))
                stc_pkg::CFG_ENABLE: r_enable <= i_cfg_data[0];
                stc_pkg::CFG_B_LEN:  r_b_len  <= i_cfg_data[stc_pkg::LEN_W-1:0];
                stc_pkg::CFG_A_LEN:  r_a_len  <= i_cfg_data[stc_pkg::LEN_W-1:0];
                stc_pkg::CFG_B_COEF: r_b_coef <= i_cfg_data[$bits(r_b_coef)-1:0];
                stc_pkg::CFG_A_COEF: r_a_coef <= i_cfg_data[$bits(r_a_coef)-1:0];
                stc_pkg::CFG_GCOUNT: r_gcount <= i_cfg_data[stc_pkg::GCNT_W-1:0];
                default: ;
            endcase
        end
    end

    // Clearing pass over the history RAMs after reset.
    logic                          r_clear;
    logic [stc_pkg::HIST_AW-1:0]   r_clr_addr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clear    <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_clear) begin
            r_clr_addr <= r_clr_addr + 1'b1;
            if (&r_clr_addr) begin
                r_clear <= 1'b0;
            end
        end
    end

    // The whole pipeline advances together whenever the output register is
    // free or its transfer completes, so a stall drops and repeats nothing.
    logic                   en, hazard, in_xfer;
    logic                   r_v1, r_v2, r_v3, r_out_valid;
    stc_pkg::t_meta         r_s1, r_s2, r_s3, n_s1;
    logic [SLOT_W_C-1:0]    r_slot;

    assign en = !r_out_valid || i_ready;

    // A sample whose gate is still being filtered must wait, since its
    // history words are not in the RAM yet and its output feeds back.
    always_comb begin
        hazard = 1'b0;
        if (r_v1 && r_s1.filt && r_s1.pol == i_polarization && r_s1.gate == i_gate) hazard = 1'b1;
        if (r_v2 && r_s2.filt && r_s2.pol == i_polarization && r_s2.gate == i_gate) hazard = 1'b1;
        if (r_v3 && r_s3.filt && r_s3.pol == i_polarization && r_s3.gate == i_gate) hazard = 1'b1;
    end

    assign o_ready = en && !r_clear && !hazard;
    assign in_xfer = i_valid && o_ready;

    always_comb begin
        n_s1.x.i  = i_sample_i;
        n_s1.x.q  = i_sample_q;
        n_s1.pol  = i_polarization;
        n_s1.gate = i_gate;
        n_s1.last = i_pulse_end;
        n_s1.slot = r_slot;
        n_s1.filt = r_enable;
        n_s1.pass = {1'b0, i_gate} >= r_gcount;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1        <= 1'b0;
            r_v2        <= 1'b0;
            r_v3        <= 1'b0;
            r_out_valid <= 1'b0;
            r_slot      <= '0;
        end else begin
            if (en) begin
                r_v1        <= in_xfer;
                r_v2        <= r_v1;
                r_v3        <= r_v2;
                r_out_valid <= r_v3;
            end
            if (in_xfer && r_enable && i_pulse_end) begin
                r_slot <= r_slot + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s1 <= n_s1;
            r_s2 <= r_s1;
            r_s3 <= r_s2;
        end
    end

    // One RAM per pulse slot, each word holding the input and output sample.
    logic                          wr_go;
    logic [stc_pkg::HIST_AW-1:0]   wr_addr;
    logic [HW-1:0]                 wr_data;
    logic [HW-1:0]                 rd_data [TAPS];
    stc_pkg::t_cplx                y_sat;

    assign wr_go   = en && r_v3 && r_s3.filt;
    assign wr_addr = r_clear ? r_clr_addr : {r_s3.pol, r_s3.gate};
    assign wr_data = r_clear ? '0 : {y_sat, r_s3.x};

    for (genvar k = 0; k < TAPS; k++) begin : g_slot
        stc_ram #(
            .WIDTH (HW),
            .DEPTH (stc_pkg::HIST_DEPTH)
        ) u_ram (
            .i_clk   (i_clk),
            .i_we    (r_clear || (wr_go && r_s3.slot == SLOT_W_C'(k))),
            .i_waddr (wr_addr),
            .i_wdata (wr_data),
            .i_re    (en),
            .i_raddr ({i_polarization, i_gate}),
            .o_rdata (rd_data[k])
        );
    end

    // Tap selection: tap j comes from the slot j pulses back; unused taps
    // get a zero coefficient.
    stc_pkg::t_cplx  x_tap [TAPS];
    stc_pkg::t_cplx  y_tap [TAPS-1];
    stc_pkg::t_coef  b_c   [TAPS];
    stc_pkg::t_coef  a_c   [TAPS-1];
    logic [SLOT_W_C-1:0] sidx [TAPS];

    always_comb begin
        x_tap[0] = r_s1.x;
        sidx[0]  = r_s1.slot;
        for (int j = 1; j < TAPS; j++) begin
            sidx[j]    = r_s1.slot - SLOT_W_C'(j);
            x_tap[j]   = rd_data[sidx[j]][HW/2-1:0];
            y_tap[j-1] = rd_data[sidx[j]][HW-1:HW/2];
        end
        for (int j = 0; j < TAPS; j++) begin
            b_c[j] = (r_b_len > stc_pkg::LEN_W'(j)) ?
                     r_b_coef[j*stc_pkg::COEF_W +: stc_pkg::COEF_W] : '0;
        end
        for (int j = 1; j < TAPS; j++) begin
            a_c[j-1] = (r_a_len > stc_pkg::LEN_W'(j)) ?
                       r_a_coef[(j-1)*stc_pkg::COEF_W +: stc_pkg::COEF_W] : '0;
        end
    end

    stc_pkg::t_acc acc_i, acc_q;

    stc_mac u_mac (
        .i_clk   (i_clk),
        .i_en    (en),
        .i_x_tap (x_tap),
        .i_y_tap (y_tap),
        .i_b     (b_c),
        .i_a     (a_c),
        .o_acc_i (acc_i),
        .o_acc_q (acc_q)
    );

    // Round half up to Q1.15, then saturate to 16 bits.
    function automatic stc_pkg::t_smp round_sat(input stc_pkg::t_acc acc);
        logic signed [stc_pkg::ACC_W:0] t;
        logic signed [QW-1:0] q;
        t = (stc_pkg::ACC_W+1)'(acc) + (stc_pkg::ACC_W+1)'(2048);
        q = QW'(t >>> stc_pkg::FRAC_SHIFT);
        if (q > QW'(32767)) begin
            return stc_pkg::t_smp'(16'sh7fff);
        end else if (q < -QW'(32768)) begin
            return stc_pkg::t_smp'(16'sh8000);
        end
        return stc_pkg::t_smp'(q);
    endfunction

    assign y_sat.i = round_sat(acc_i);
    assign y_sat.q = round_sat(acc_q);

    // Output register.
    stc_pkg::t_cplx r_y;
    logic           r_o_pol, r_o_last;
    logic [stc_pkg::GATE_W-1:0] r_o_gate;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_y      <= (r_s3.filt && !r_s3.pass) ? y_sat : r_s3.x;
            r_o_pol  <= r_s3.pol;
            r_o_gate <= r_s3.gate;
            r_o_last <= r_s3.last;
        end
    end

    assign o_valid            = r_out_valid;
    assign o_filtered_i       = r_y.i;
    assign o_filtered_q       = r_y.q;
    assign o_out_polarization = r_o_pol;
    assign o_out_gate         = r_o_gate;
    assign o_out_pulse_end    = r_o_last;

    `STC_NEVER(a_no_xfer_in_clear, i_clk, i_rst_n, in_xfer && r_clear)
    `STC_NEVER(a_no_write_in_clear, i_clk, i_rst_n, r_clear && r_v3)
    `STC_NEVER(a_s1_s2_distinct, i_clk, i_rst_n, r_v1 && r_v2 && r_s1.filt && r_s2.filt && r_s1.pol == r_s2.pol && r_s1.gate == r_s2.gate)
    `STC_ASSERT(a_stall_holds, i_clk, i_rst_n, (r_out_valid && !i_ready) |=> $stable(r_v3))
endmodule

### src/stc_ram.sv
// Generic single-write, single-read RAM with registered read data.
module stc_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 8192
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

### src/stc_mac.sv
// Two-stage multiply-accumulate for the I and Q filter sums.
module stc_mac (
    input  logic              i_clk,
    input  logic              i_en,
    input  stc_pkg::t_cplx    i_x_tap [stc_pkg::TAPS],
    input  stc_pkg::t_cplx    i_y_tap [stc_pkg::TAPS-1],
    input  stc_pkg::t_coef    i_b     [stc_pkg::TAPS],
    input  stc_pkg::t_coef    i_a     [stc_pkg::TAPS-1],
    output stc_pkg::t_acc     o_acc_i,
    output stc_pkg::t_acc     o_acc_q
);
    localparam int NP = 2 * stc_pkg::TAPS - 1;

    logic signed [stc_pkg::PROD_W-1:0] r_pi [NP];
    logic signed [stc_pkg::PROD_W-1:0] r_pq [NP];
    stc_pkg::t_acc r_acc_i, r_acc_q, n_acc_i, n_acc_q;

    // Feedback products are negated in the sum stage.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int j = 0; j < stc_pkg::TAPS; j++) begin
                r_pi[j] <= i_x_tap[j].i * i_b[j];
                r_pq[j] <= i_x_tap[j].q * i_b[j];
            end
            for (int j = 0; j < stc_pkg::TAPS - 1; j++) begin
                r_pi[stc_pkg::TAPS + j] <= i_y_tap[j].i * i_a[j];
                r_pq[stc_pkg::TAPS + j] <= i_y_tap[j].q * i_a[j];
            end
            r_acc_i <= n_acc_i;
            r_acc_q <= n_acc_q;
        end
    end

    always_comb begin
        n_acc_i = '0;
        n_acc_q = '0;
        for (int j = 0; j < NP; j++) begin
            if (j < stc_pkg::TAPS) begin
                n_acc_i = n_acc_i + stc_pkg::ACC_W'(r_pi[j]);
                n_acc_q = n_acc_q + stc_pkg::ACC_W'(r_pq[j]);
            end else begin
                n_acc_i = n_acc_i - stc_pkg::ACC_W'(r_pi[j]);
                n_acc_q = n_acc_q - stc_pkg::ACC_W'(r_pq[j]);
            end
        end
    end

    assign o_acc_i = r_acc_i;
    assign o_acc_q = r_acc_q;
endmodule
